// ----- src/cmt_pkg.sv -----
`default_nettype none

package cmt_pkg;

    localparam int PORT_CFG_W = 3;
    localparam int SLOT_CFG_W = 5;

    // input function codes
    localparam logic [2:0] FUNC_ADD    = 3'd0;
    localparam logic [2:0] FUNC_DELETE = 3'd1;
    localparam logic [2:0] FUNC_CLEAR  = 3'd2;
    localparam logic [2:0] FUNC_LOOKUP = 3'd3;
    localparam logic [2:0] FUNC_SEARCH = 3'd4;
    localparam logic [2:0] FUNC_LIST   = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // register index, decoded from paddr[2]
    localparam logic REG_PORTS = 1'b0;
    localparam logic REG_SLOTS = 1'b1;

    // stored entry: valid, type, source port, source slot
    localparam int ENTRY_W = 21;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_DELETE,
        OP_CLEAR,
        OP_LOOKUP,
        OP_SEARCH,
        OP_LIST,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic                  in_range;
        logic [7:0]            src_port;
        logic [7:0]            src_slot;
        logic [PORT_CFG_W-1:0] dst_port;
        logic [SLOT_CFG_W-1:0] dst_slot;
        logic [3:0]            conn_type;
        logic [PORT_CFG_W-1:0] num_ports;
        logic [SLOT_CFG_W-1:0] num_slots;
    } cmt_item_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic [3:0] rtype;
        logic [7:0] sport;
        logic [7:0] sslot;
        logic [7:0] dport;
        logic [7:0] dslot;
        logic       last;
    } cmt_result_t;

endpackage

`default_nettype wire

// ----- src/cmt_front.sv -----
`default_nettype none

module cmt_front #(
    parameter int MAX_PORTS = 4,
    parameter int MAX_SLOTS = 16
) (
    input  wire logic                           accept,
    input  wire logic [2:0]                     func,
    input  wire logic [7:0]                     src_port,
    input  wire logic [7:0]                     src_slot,
    input  wire logic [7:0]                     dst_port,
    input  wire logic [7:0]                     dst_slot,
    input  wire logic [3:0]                     conn_type,
    input  wire logic [cmt_pkg::PORT_CFG_W-1:0] ports_cfg,
    input  wire logic [cmt_pkg::SLOT_CFG_W-1:0] slots_cfg,
    output logic                                push,
    output cmt_pkg::cmt_item_t                  item
);
    import cmt_pkg::*;

    logic [PORT_CFG_W-1:0] np_eff;
    logic [SLOT_CFG_W-1:0] ns_eff;
    logic                  dst_ok;
    logic                  src_ok;

    always_comb
    begin
        np_eff = (32'(ports_cfg) > MAX_PORTS) ? PORT_CFG_W'(MAX_PORTS) : ports_cfg;
        ns_eff = (32'(slots_cfg) > MAX_SLOTS) ? SLOT_CFG_W'(MAX_SLOTS) : slots_cfg;
        dst_ok = (dst_port < 8'(np_eff)) && (dst_slot < 8'(ns_eff));
        src_ok = (src_port < 8'(np_eff)) && (src_slot < 8'(ns_eff));
    end

    always_comb
    begin
        item.src_port  = src_port;
        item.src_slot  = src_slot;
        item.dst_port  = dst_port[PORT_CFG_W-1:0];
        item.dst_slot  = dst_slot[SLOT_CFG_W-1:0];
        item.conn_type = conn_type;
        item.num_ports = np_eff;
        item.num_slots = ns_eff;
        case (func)
            FUNC_ADD:
            begin
                item.op       = OP_ADD;
                item.in_range = dst_ok && src_ok;
            end
            FUNC_DELETE:
            begin
                item.op       = OP_DELETE;
                item.in_range = dst_ok;
            end
            FUNC_CLEAR:
            begin
                item.op       = OP_CLEAR;
                item.in_range = 1'b1;
            end
            FUNC_LOOKUP:
            begin
                item.op       = OP_LOOKUP;
                item.in_range = dst_ok;
            end
            FUNC_SEARCH:
            begin
                item.op       = OP_SEARCH;
                item.in_range = 1'b1;
            end
            FUNC_LIST:
            begin
                item.op       = OP_LIST;
                item.in_range = 1'b1;
            end
            default:
            begin
                item.op       = OP_BAD;
                item.in_range = 1'b0;
            end
        endcase
    end

    assign push = accept;

endmodule

`default_nettype wire

// ----- src/cmt_queue.sv -----
`default_nettype none

module cmt_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cmt_pkg::cmt_item_t push_item,
    input  wire logic               pop,
    output logic                    head_valid,
    output cmt_pkg::cmt_item_t      head,
    output logic                    full
);
    import cmt_pkg::*;

    cmt_item_t  slots_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid = (count_reg != 2'd0);
    assign head       = slots_reg[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("transfer pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ----- src/cmt_back.sv -----
`default_nettype none

module cmt_back #(
    parameter int MAX_PORTS = 4,
    parameter int MAX_SLOTS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire cmt_pkg::cmt_item_t head,
    output logic                    pop,
    output logic                    init_busy,
    output cmt_pkg::cmt_result_t    result
);
    import cmt_pkg::*;

    localparam int NUM_ENTRIES = MAX_PORTS * MAX_SLOTS;
    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] SLOT_STRIDE = IDX_W'(MAX_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CLEAR = 6'b000100,
        S_LOOK  = 6'b001000,
        S_WALK  = 6'b010000,
        S_DRAIN = 6'b100000
    } state_t;

    // final report of a walk is made while in S_IDLE, flagged by fin_reg
    state_t                state_reg;
    state_t                state_next;
    logic                  fin_reg;
    logic                  fin_next;
    cmt_item_t             cur_reg;
    logic [IDX_W-1:0]      sweep_reg;
    logic [IDX_W-1:0]      sweep_next;
    logic [PORT_CFG_W-1:0] p_reg;
    logic [PORT_CFG_W-1:0] p_next;
    logic [SLOT_CFG_W-1:0] s_reg;
    logic [SLOT_CFG_W-1:0] s_next;
    logic [IDX_W-1:0]      row_reg;
    logic [IDX_W-1:0]      row_next;
    logic                  rd_walk_reg;
    logic                  rd_walk_next;
    logic [PORT_CFG_W-1:0] rd_p_reg;
    logic [SLOT_CFG_W-1:0] rd_s_reg;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [19:0]           pend_word_reg;
    logic [19:0]           pend_word_next;
    logic [PORT_CFG_W-1:0] pend_p_reg;
    logic [PORT_CFG_W-1:0] pend_p_next;
    logic [SLOT_CFG_W-1:0] pend_s_reg;
    logic [SLOT_CFG_W-1:0] pend_s_next;
    cmt_result_t           res_reg;
    cmt_result_t           res_next;

    logic [ENTRY_W-1:0]    mem [NUM_ENTRIES];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      head_idx;
    logic                  walk_last;
    logic                  slot_last;
    logic                  hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        head_idx  = IDX_W'(head.dst_port) * SLOT_STRIDE + IDX_W'(head.dst_slot);
        slot_last = ({1'b0, s_reg} + 6'd1) == {1'b0, cur_reg.num_slots};
        walk_last = slot_last &&
                    (({1'b0, p_reg} + 4'd1) == {1'b0, cur_reg.num_ports});
        hit = rd_walk_reg && rd_data_reg[20] &&
              ((cur_reg.op == OP_LIST) ||
               ((rd_data_reg[15:8] == cur_reg.src_port) &&
                (rd_data_reg[7:0] == cur_reg.src_slot)));
    end

    always_comb
    begin
        state_next      = state_reg;
        fin_next        = 1'b0;
        pop             = 1'b0;
        sweep_next      = sweep_reg;
        p_next          = p_reg;
        s_next          = s_reg;
        row_next        = row_reg;
        rd_walk_next    = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_word_next  = pend_word_reg;
        pend_p_next     = pend_p_reg;
        pend_s_next     = pend_s_reg;
        wr_en           = 1'b0;
        wr_addr         = sweep_reg;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = row_reg + IDX_W'(s_reg);
        res_next        = '0;
        res_next.last   = 1'b1;

        // collect walk hits; hold the newest so the final one can carry last
        if (hit)
        begin
            if (pend_valid_reg)
            begin
                res_next.valid  = 1'b1;
                res_next.status = ST_OK;
                res_next.rtype  = pend_word_reg[19:16];
                res_next.sport  = pend_word_reg[15:8];
                res_next.sslot  = pend_word_reg[7:0];
                res_next.dport  = 8'(pend_p_reg);
                res_next.dslot  = 8'(pend_s_reg);
                res_next.last   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_word_next  = rd_data_reg[19:0];
            pend_p_next     = rd_p_reg;
            pend_s_next     = rd_s_reg;
        end

        if (fin_reg)
        begin
            res_next.valid  = 1'b1;
            res_next.last   = 1'b1;
            if (pend_valid_reg)
            begin
                res_next.status = ST_OK;
                res_next.rtype  = pend_word_reg[19:16];
                res_next.sport  = pend_word_reg[15:8];
                res_next.sslot  = pend_word_reg[7:0];
                res_next.dport  = 8'(pend_p_reg);
                res_next.dslot  = 8'(pend_s_reg);
            end
            else
            begin
                res_next.status = ST_NONE;
            end
            pend_valid_next = 1'b0;
        end
        else
        begin
            case (state_reg)
                S_INIT, S_CLEAR:
                begin
                    wr_en      = 1'b1;
                    sweep_next = sweep_reg + IDX_W'(1);
                    if (sweep_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                        if (state_reg == S_CLEAR)
                        begin
                            res_next.valid  = 1'b1;
                            res_next.status = ST_OK;
                        end
                    end
                end
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        pop = 1'b1;
                        case (head.op)
                            OP_ADD, OP_DELETE:
                            begin
                                wr_en   = head.in_range;
                                wr_addr = head_idx;
                                if (head.op == OP_ADD)
                                begin
                                    wr_data = {1'b1, head.conn_type, head.src_port,
                                               head.src_slot};
                                end
                                res_next.valid  = 1'b1;
                                res_next.status = head.in_range ? ST_OK : ST_RANGE;
                            end
                            OP_CLEAR:
                            begin
                                sweep_next = '0;
                                state_next = S_CLEAR;
                            end
                            OP_LOOKUP:
                            begin
                                if (head.in_range)
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = head_idx;
                                    state_next = S_LOOK;
                                end
                                else
                                begin
                                    res_next.valid  = 1'b1;
                                    res_next.status = ST_RANGE;
                                end
                            end
                            OP_SEARCH, OP_LIST:
                            begin
                                p_next   = '0;
                                s_next   = '0;
                                row_next = '0;
                                if ((head.num_ports == '0) || (head.num_slots == '0))
                                begin
                                    fin_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_WALK;
                                end
                            end
                            default:
                            begin
                                res_next.valid  = 1'b1;
                                res_next.status = ST_RANGE;
                            end
                        endcase
                    end
                end
                S_LOOK:
                begin
                    res_next.valid = 1'b1;
                    if (rd_data_reg[20])
                    begin
                        res_next.status = ST_OK;
                        res_next.rtype  = rd_data_reg[19:16];
                        res_next.sport  = rd_data_reg[15:8];
                        res_next.sslot  = rd_data_reg[7:0];
                        res_next.dport  = 8'(cur_reg.dst_port);
                        res_next.dslot  = 8'(cur_reg.dst_slot);
                    end
                    else
                    begin
                        res_next.status = ST_NONE;
                    end
                    state_next = S_IDLE;
                end
                S_WALK:
                begin
                    rd_en        = 1'b1;
                    rd_walk_next = 1'b1;
                    if (slot_last)
                    begin
                        s_next   = '0;
                        p_next   = p_reg + PORT_CFG_W'(1);
                        row_next = row_reg + SLOT_STRIDE;
                    end
                    else
                    begin
                        s_next = s_reg + SLOT_CFG_W'(1);
                    end
                    if (walk_last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    // last read is checked this cycle, report on the next
                    fin_next   = 1'b1;
                    state_next = S_IDLE;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            fin_reg        <= 1'b0;
            sweep_reg      <= '0;
            rd_walk_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fin_reg        <= fin_next;
            sweep_reg      <= sweep_next;
            rd_walk_reg    <= rd_walk_next;
            pend_valid_reg <= pend_valid_next;
            res_reg        <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        p_reg         <= p_next;
        s_reg         <= s_next;
        row_reg       <= row_next;
        rd_p_reg      <= p_reg;
        rd_s_reg      <= s_reg;
        pend_word_reg <= pend_word_next;
        pend_p_reg    <= pend_p_next;
        pend_s_reg    <= pend_s_next;
    end

    assign init_busy = (state_reg == S_INIT);
    assign result    = res_reg;

`ifndef SYNTHESIS
    a_quiet_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |=> !res_reg.valid)
        else $error("result produced during the reset sweep");

    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_reg.valid && !res_reg.last) |-> (res_reg.status == ST_OK))
        else $error("non-final result without a found entry");

    a_pend_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |=> !pend_valid_reg)
        else $error("held walk entry survives the final report");

    a_walk_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_walk_reg |-> ((state_reg == S_WALK) || (state_reg == S_DRAIN)))
        else $error("walk read data outside a walk");
`endif

endmodule

`default_nettype wire

// ----- src/crossconnect_map_table_top.sv -----
`default_nettype none

// Crossconnect map: one entry per (destination port, destination timeslot),
// MAX_PORTS * MAX_SLOTS entries in a memory with one write and one read
// port. An item is taken when start is high and busy is low; a two-deep
// queue sits between the decode front and the table engine, so busy rises
// only when that queue is full or while the table is being wiped after reset.
// With the engine idle, add, delete, unknown and out-of-range items report
// once the engine has popped them from the queue; a lookup first reads the
// memory and reports from the read data. Clear-all sweeps every entry, one
// per cycle, and reports after writing the last entry. Search and list read
// the configured region (ports_reg by slots_reg, each capped at its
// parameter) one entry per cycle through the memory's read port and give
// their final result once the last read is checked, or with no reads when
// the region is empty; each hit is one transfer. The engine starts the next
// item only once the current one is done, so the walk sets the time per item.
// Results appear for one cycle with res_valid and cannot be stalled; last marks the final result of each item.
module crossconnect_map_table_top #(
    parameter int MAX_PORTS = 4,
    parameter int MAX_SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  func,
    input  wire logic [7:0]  src_port,
    input  wire logic [7:0]  src_slot,
    input  wire logic [7:0]  dst_port,
    input  wire logic [7:0]  dst_slot,
    input  wire logic [3:0]  conn_type,
    output logic             res_valid,
    output logic [1:0]       status,
    output logic [3:0]       res_type,
    output logic [7:0]       res_src_port,
    output logic [7:0]       res_src_slot,
    output logic [7:0]       res_dst_port,
    output logic [7:0]       res_dst_slot,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import cmt_pkg::*;

    logic [PORT_CFG_W-1:0] ports_reg;
    logic [SLOT_CFG_W-1:0] slots_reg;
    logic                  cfg_wr;
    logic                  accept;
    logic                  push;
    cmt_item_t             push_item;
    logic                  pop;
    logic                  head_valid;
    cmt_item_t             head;
    logic                  q_full;
    logic                  init_busy;
    cmt_result_t           result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ports_reg <= PORT_CFG_W'(4);
            slots_reg <= SLOT_CFG_W'(16);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_PORTS: ports_reg <= pwdata[PORT_CFG_W-1:0];
                REG_SLOTS: slots_reg <= pwdata[SLOT_CFG_W-1:0];
                default:   ports_reg <= ports_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PORTS: prdata = 32'(ports_reg);
            REG_SLOTS: prdata = 32'(slots_reg);
            default:   prdata = '0;
        endcase
    end

    assign busy   = q_full || init_busy;
    assign accept = start && !busy;

    cmt_front #(
        .MAX_PORTS (MAX_PORTS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .accept    (accept),
        .func      (func),
        .src_port  (src_port),
        .src_slot  (src_slot),
        .dst_port  (dst_port),
        .dst_slot  (dst_slot),
        .conn_type (conn_type),
        .ports_cfg (ports_reg),
        .slots_cfg (slots_reg),
        .push      (push),
        .item      (push_item)
    );

    cmt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (q_full)
    );

    cmt_back #(
        .MAX_PORTS (MAX_PORTS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .init_busy  (init_busy),
        .result     (result)
    );

    assign res_valid    = result.valid;
    assign status       = result.status;
    assign res_type     = result.rtype;
    assign res_src_port = result.sport;
    assign res_src_slot = result.sslot;
    assign res_dst_port = result.dport;
    assign res_dst_slot = result.dslot;
    assign last         = result.last;

endmodule

`default_nettype wire

// ----- dv/crossconnect_map_table_top_tb.sv -----
`timescale 1ns / 1ps

module crossconnect_map_table_top_tb;

    import cmt_pkg::*;

    localparam int MAX_PORTS   = 4;
    localparam int MAX_SLOTS   = 16;
    localparam int NUM_ENTRIES = MAX_PORTS * MAX_SLOTS;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    // func codes the block does not implement
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] src_port;
        logic [7:0] src_slot;
        logic [7:0] dst_port;
        logic [7:0] dst_slot;
        logic [3:0] conn_type;
    } map_cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] rtype;
        logic [7:0] sport;
        logic [7:0] sslot;
        logic [7:0] dport;
        logic [7:0] dslot;
        logic       last;
    } map_report_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [2:0]  func      = '0;
    logic [7:0]  src_port  = '0;
    logic [7:0]  src_slot  = '0;
    logic [7:0]  dst_port  = '0;
    logic [7:0]  dst_slot  = '0;
    logic [3:0]  conn_type = '0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic        busy;
    logic        res_valid;
    logic [1:0]  status;
    logic [3:0]  res_type;
    logic [7:0]  res_src_port;
    logic [7:0]  res_src_slot;
    logic [7:0]  res_dst_port;
    logic [7:0]  res_dst_slot;
    logic        last;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the connection map and its limits
    logic        map_valid [NUM_ENTRIES];
    logic [19:0] map_word  [NUM_ENTRIES];
    logic [2:0]  cfg_ports = 3'd4;
    logic [4:0]  cfg_slots = 5'd16;

    map_cmd_t    pending_cmds[$];
    map_report_t expected_reports[$];
    int          gap_pct = 30;
    bit          failed  = 1'b0;
    int          stall_cnt = 0;

    crossconnect_map_table_top #(
        .MAX_PORTS(MAX_PORTS),
        .MAX_SLOTS(MAX_SLOTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .src_port     (src_port),
        .src_slot     (src_slot),
        .dst_port     (dst_port),
        .dst_slot     (dst_slot),
        .conn_type    (conn_type),
        .res_valid    (res_valid),
        .status       (status),
        .res_type     (res_type),
        .res_src_port (res_src_port),
        .res_src_slot (res_src_slot),
        .res_dst_port (res_dst_port),
        .res_dst_slot (res_dst_slot),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_ports();
        return (cfg_ports > MAX_PORTS) ? MAX_PORTS : cfg_ports;
    endfunction

    function automatic int unsigned eff_slots();
        return (cfg_slots > MAX_SLOTS) ? MAX_SLOTS : cfg_slots;
    endfunction

    task automatic push_report(input logic [1:0] st, input logic [19:0] word,
                               input logic [7:0] dp, input logic [7:0] ds,
                               input logic lst);
        map_report_t r;
        r.status = st;
        r.rtype  = word[19:16];
        r.sport  = word[15:8];
        r.sslot  = word[7:0];
        r.dport  = dp;
        r.dslot  = ds;
        r.last   = lst;
        expected_reports.insert(expected_reports.size(), r);
    endtask

    // walk port-major over the region in service; search keeps matching sources only
    task automatic walk_map(input bool_match, input logic [7:0] sp, input logic [7:0] ss);
        int unsigned np;
        int unsigned ns;
        int unsigned i;
        int          hits;
        map_report_t tail;
        np   = eff_ports();
        ns   = eff_slots();
        hits = 0;
        for (int unsigned p = 0; p < np; p++)
        begin
            for (int unsigned s = 0; s < ns; s++)
            begin
                i = p * MAX_SLOTS + s;
                if (map_valid[i] &&
                    (!bool_match || (map_word[i][15:8] == sp && map_word[i][7:0] == ss)))
                begin
                    push_report(ST_OK, map_word[i], p[7:0], s[7:0], 1'b0);
                    hits++;
                end
            end
        end
        if (hits == 0)
        begin
            push_report(ST_NONE, '0, '0, '0, 1'b1);
        end
        else
        begin
            tail = expected_reports.pop_back();
            tail.last = 1'b1;
            expected_reports.insert(expected_reports.size(), tail);
        end
    endtask

    task automatic apply_to_map(input map_cmd_t c);
        int unsigned np;
        int unsigned ns;
        int unsigned idx;
        logic        dst_ok;
        np     = eff_ports();
        ns     = eff_slots();
        dst_ok = (c.dst_port < np) && (c.dst_slot < ns);
        idx    = dst_ok ? c.dst_port * MAX_SLOTS + c.dst_slot : 0;
        case (c.func)
            FUNC_ADD:
            begin
                if (!dst_ok || c.src_port >= np || c.src_slot >= ns)
                begin
                    push_report(ST_RANGE, '0, '0, '0, 1'b1);
                end
                else
                begin
                    map_word[idx]  = {c.conn_type, c.src_port, c.src_slot};
                    map_valid[idx] = 1'b1;
                    push_report(ST_OK, '0, '0, '0, 1'b1);
                end
            end
            FUNC_DELETE:
            begin
                if (!dst_ok)
                begin
                    push_report(ST_RANGE, '0, '0, '0, 1'b1);
                end
                else
                begin
                    map_valid[idx] = 1'b0;
                    push_report(ST_OK, '0, '0, '0, 1'b1);
                end
            end
            FUNC_CLEAR:
            begin
                foreach (map_valid[i])
                begin
                    map_valid[i] = 1'b0;
                end
                push_report(ST_OK, '0, '0, '0, 1'b1);
            end
            FUNC_LOOKUP:
            begin
                if (!dst_ok)
                begin
                    push_report(ST_RANGE, '0, '0, '0, 1'b1);
                end
                else if (map_valid[idx])
                begin
                    push_report(ST_OK, map_word[idx], c.dst_port, c.dst_slot, 1'b1);
                end
                else
                begin
                    push_report(ST_NONE, '0, '0, '0, 1'b1);
                end
            end
            FUNC_SEARCH:
            begin
                walk_map(1'b1, c.src_port, c.src_slot);
            end
            FUNC_LIST:
            begin
                walk_map(1'b0, '0, '0);
            end
            default:
            begin
                push_report(ST_RANGE, '0, '0, '0, 1'b1);
            end
        endcase
    endtask

    // mostly in service, sometimes the first rejected number or full-width noise
    function automatic logic [7:0] pick_num(input int unsigned lim);
        int unsigned r;
        r = $urandom_range(99);
        if (lim == 0 || r < 8)
        begin
            return 8'($urandom());
        end
        if (r < 14)
        begin
            return lim[7:0];
        end
        return 8'($urandom_range(lim - 1));
    endfunction

    function automatic map_cmd_t rand_cmd();
        map_cmd_t    c;
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(99);
        if (roll < 34)      c.func = FUNC_ADD;
        else if (roll < 44) c.func = FUNC_DELETE;
        else if (roll < 46) c.func = FUNC_CLEAR;
        else if (roll < 68) c.func = FUNC_LOOKUP;
        else if (roll < 86) c.func = FUNC_SEARCH;
        else if (roll < 95) c.func = FUNC_LIST;
        else if (roll < 97) c.func = FUNC_UNUSED_LO;
        else                c.func = FUNC_UNUSED_HI;
        c.src_port  = pick_num(eff_ports());
        c.src_slot  = pick_num(eff_slots());
        c.dst_port  = pick_num(eff_ports());
        c.dst_slot  = pick_num(eff_slots());
        c.conn_type = 4'($urandom());
        // aim half the searches at a source already stored
        if (c.func == FUNC_SEARCH && $urandom_range(1) == 1)
        begin
            pick = $urandom_range(NUM_ENTRIES - 1);
            if (map_valid[pick])
            begin
                c.src_port = map_word[pick][15:8];
                c.src_slot = map_word[pick][7:0];
            end
        end
        return c;
    endfunction

    task automatic push_cmd(input logic [2:0] f, input logic [7:0] sp, input logic [7:0] ss,
                            input logic [7:0] dp, input logic [7:0] ds, input logic [3:0] ty);
        pending_cmds.insert(pending_cmds.size(), {f, sp, ss, dp, ds, ty});
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limits(input logic [2:0] ports, input logic [4:0] slots);
        logic [31:0] word;
        word      = $urandom();
        word[2:0] = ports;
        write_reg({REG_PORTS, 2'b00}, word);
        cfg_ports = ports;
        word      = $urandom();
        word[4:0] = slots;
        write_reg({REG_SLOTS, 2'b00}, word);
        cfg_slots = slots;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_cmds.size() != 0 || expected_reports.size() != 0 || start || busy)
        begin
            @(negedge clk);
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // command driver: hold start while busy, otherwise advance or idle at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_to_map(pending_cmds.pop_front());
            end
            if (!(start && busy))
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    start     <= 1'b1;
                    func      <= pending_cmds[0].func;
                    src_port  <= pending_cmds[0].src_port;
                    src_slot  <= pending_cmds[0].src_slot;
                    dst_port  <= pending_cmds[0].dst_port;
                    dst_slot  <= pending_cmds[0].dst_slot;
                    conn_type <= pending_cmds[0].conn_type;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        map_report_t want;
        if (rst_n && res_valid)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result transfer with nothing expected: status %0d", status);
                failed = 1'b1;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("status",       want.status, status);
                check_field("res_type",     want.rtype,  res_type);
                check_field("res_src_port", want.sport,  res_src_port);
                check_field("res_src_slot", want.sslot,  res_src_slot);
                check_field("res_dst_port", want.dport,  res_dst_port);
                check_field("res_dst_slot", want.dslot,  res_dst_slot);
                check_field("last",         want.last,   last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || res_valid)
        begin
            stall_cnt <= 0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] phase_ports [8];
        logic [4:0] phase_slots [8];
        phase_ports = '{3'd2, 3'd0, 3'd7, 3'd1, 3'd4, 3'd3, 3'd6, 3'd4};
        phase_slots = '{5'd8, 5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd12, 5'd16};
        foreach (map_valid[i])
        begin
            map_valid[i] = 1'b0;
            map_word[i]  = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // table wipe after reset holds busy high
        wait_drained();
        set_limits(3'd4, 5'd16);
        @(negedge clk);
        push_cmd(FUNC_LIST,   0,   0,   0,   0,   0);
        push_cmd(FUNC_SEARCH, 0,   0,   0,   0,   0);
        push_cmd(FUNC_LOOKUP, 0,   0,   0,   0,   0);
        push_cmd(FUNC_ADD,    3,   15,  0,   0,   15);
        push_cmd(FUNC_ADD,    0,   0,   3,   15,  0);
        push_cmd(FUNC_ADD,    3,   15,  1,   5,   10);
        push_cmd(FUNC_ADD,    0,   0,   4,   0,   7);
        push_cmd(FUNC_ADD,    0,   16,  0,   0,   7);
        push_cmd(FUNC_ADD,    255, 255, 255, 255, 15);
        push_cmd(FUNC_ADD,    4,   0,   2,   2,   3);
        push_cmd(FUNC_LOOKUP, 0,   0,   0,   0,   0);
        push_cmd(FUNC_LOOKUP, 0,   0,   3,   15,  0);
        push_cmd(FUNC_LOOKUP, 0,   0,   255, 255, 0);
        push_cmd(FUNC_LOOKUP, 0,   0,   0,   16,  0);
        push_cmd(FUNC_SEARCH, 3,   15,  0,   0,   0);
        push_cmd(FUNC_SEARCH, 255, 255, 0,   0,   0);
        push_cmd(FUNC_LIST,   0,   0,   0,   0,   0);
        push_cmd(FUNC_DELETE, 0,   0,   1,   5,   0);
        push_cmd(FUNC_DELETE, 0,   0,   2,   2,   0);
        push_cmd(FUNC_DELETE, 0,   0,   4,   0,   0);
        push_cmd(FUNC_UNUSED_LO, 255, 255, 255, 255, 15);
        push_cmd(FUNC_UNUSED_HI, 0,   0,   0,   0,   0);
        push_cmd(FUNC_CLEAR,  0,   0,   0,   0,   0);
        push_cmd(FUNC_LIST,   0,   0,   0,   0,   0);
        push_cmd(FUNC_ADD,    1,   2,   3,   14,  5);
        push_cmd(FUNC_ADD,    3,   1,   0,   1,   9);

        foreach (phase_ports[ph])
        begin
            wait_drained();
            set_limits(phase_ports[ph], phase_slots[ph]);
            @(negedge clk);
            // last phase runs back to back with no gaps
            gap_pct = (ph == 7) ? 0 : 30;
            repeat (32)
            begin
                pending_cmds.insert(pending_cmds.size(), rand_cmd());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
